// File: hw/rtl/rcfc_pkg.sv
// Shared types, constants and helpers of the redundant core fingerprint comparator.
package rcfc_pkg;

  localparam int TASKS        = 16;
  localparam int CORE_ID_BITS = 4;
  localparam int COUNT_BITS   = 8;
  localparam int TASK_BITS    = 4;
  localparam int FP_WIDTH     = 32;
  localparam int FP_DEPTH     = 64;
  localparam int FP_ADDR_BITS = 6;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_WIDTH    = 64;

  localparam logic [1:0] KIND_STATE = 2'd0;
  localparam logic [1:0] KIND_FP    = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam logic [2:0] VOTE_NONE     = 3'd0;
  localparam logic [2:0] VOTE_ALL      = 3'd1;
  localparam logic [2:0] VOTE_C0_OUT   = 3'd2;
  localparam logic [2:0] VOTE_C1_OUT   = 3'd3;
  localparam logic [2:0] VOTE_C2_OUT   = 3'd4;
  localparam logic [2:0] VOTE_NO_MATCH = 3'd5;

  localparam logic [CFG_IDX_BITS-1:0] REG_TRIPLE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP0    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP1    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP2    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TGT_LO  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_TGT_HI  = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  physical_core;
    logic [3:0]  task_number;
    logic        enter_flag;
    logic        half_select;
    logic [15:0] fingerprint_half;
  } rcfc_in_t;

  typedef struct packed {
    logic [31:0] success_bits;
    logic [15:0] failure_bits;
    logic        irq;
    logic        compared;
    logic [3:0]  compared_task;
    logic [2:0]  vote_result;
  } rcfc_out_t;

  // Fingerprint store address of one logical core's entry of a task.
  function automatic logic [FP_ADDR_BITS-1:0] fp_addr(logic [1:0] lc, logic [TASK_BITS-1:0] t);
    fp_addr = {lc, t};
  endfunction

  // Majority vote over three fingerprints.
  function automatic logic [2:0] vote3(logic [FP_WIDTH-1:0] a, logic [FP_WIDTH-1:0] b,
                                       logic [FP_WIDTH-1:0] c);
    logic ab, bc, ca;
    ab = (a == b);
    bc = (b == c);
    ca = (c == a);
    if (ab && bc) vote3 = VOTE_ALL;
    else if (ab)  vote3 = VOTE_C2_OUT;
    else if (bc)  vote3 = VOTE_C0_OUT;
    else if (ca)  vote3 = VOTE_C1_OUT;
    else          vote3 = VOTE_NO_MATCH;
  endfunction

endpackage

// File: hw/rtl/rcfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rcfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/redundant_core_fingerprint_comparator.sv
// Top level of the redundant core fingerprint comparator.
// A clear, a state event, a low half or a high half that finds no task ready passes through
// EXEC alone; a high half that starts a comparison goes on through RD0, RD1, RD2 and CMP,
// because the stored fingerprints of the compared task are read one per cycle from a
// single-read fingerprint RAM (three logical cores by sixteen tasks). The own entry is read
// at acceptance and written back in the following cycle. The RAM is not reset: entries never
// written read as zero through per-entry written bits. A result waits in an output register;
// the next request is taken in the cycle that result is delivered, so output stalls add
// directly to the time per request. Flags, counts and votes are small and kept in flip-flops.
module redundant_core_fingerprint_comparator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rcfc_pkg::rcfc_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rcfc_pkg::rcfc_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [rcfc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [rcfc_pkg::CFG_WIDTH-1:0]    cfg_wdata
);
  import rcfc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_RD0  = 6'b000100,
    ST_RD1  = 6'b001000,
    ST_RD2  = 6'b010000,
    ST_CMP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [TASKS-1:0] triple_r;
  logic [63:0]      map_r [3];
  logic [63:0]      tgt_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      triple_r <= '0;
      map_r[0] <= '0;
      map_r[1] <= '0;
      map_r[2] <= '0;
      tgt_r[0] <= '0;
      tgt_r[1] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIPLE: triple_r <= cfg_wdata[TASKS-1:0];
        REG_MAP0:   map_r[0] <= cfg_wdata;
        REG_MAP1:   map_r[1] <= cfg_wdata;
        REG_MAP2:   map_r[2] <= cfg_wdata;
        REG_TGT_LO: tgt_r[0] <= cfg_wdata;
        REG_TGT_HI: tgt_r[1] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Block state.
  logic [TASKS-1:0]      rdy_r [3];
  logic [TASKS-1:0]      cout_r [3];
  logic [TASKS-1:0]      cin_r [3];
  logic [FP_DEPTH-1:0]   written_r;
  logic [COUNT_BITS-1:0] cnt_r [TASKS];
  logic [2:0]            vote_r [TASKS];
  logic [31:0]           succ_r;
  logic [15:0]           fail_r;
  logic                  irq_r;

  rcfc_in_t  req_r;
  logic [1:0] lc_r;
  logic       hit_r;
  logic [TASK_BITS-1:0] ct_r;
  logic [FP_WIDTH-1:0]  fp_r [2];
  rcfc_out_t            res_r;

  // RAM ports.
  logic                    ram_we;
  logic [FP_ADDR_BITS-1:0] ram_wa, ram_ra;
  logic [FP_WIDTH-1:0]     ram_wd, ram_rd;

  rcfc_ram #(.WIDTH(FP_WIDTH), .DEPTH(FP_DEPTH)) u_fp_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_wa),
    .wr_data(ram_wd),
    .rd_addr(ram_ra),
    .rd_data(ram_rd)
  );

  // Physical to logical core lookup at accept time.
  logic [1:0] lc_in;
  logic       hit_in;
  always_comb begin
    logic [3:0] e0, e1, e2;
    e0 = map_r[0][4*in_data.task_number +: 4];
    e1 = map_r[1][4*in_data.task_number +: 4];
    e2 = map_r[2][4*in_data.task_number +: 4];
    hit_in = 1'b1;
    if (e0[CORE_ID_BITS-1:0] == in_data.physical_core[CORE_ID_BITS-1:0])      lc_in = 2'd0;
    else if (e1[CORE_ID_BITS-1:0] == in_data.physical_core[CORE_ID_BITS-1:0]) lc_in = 2'd1;
    else if (e2[CORE_ID_BITS-1:0] == in_data.physical_core[CORE_ID_BITS-1:0]) lc_in = 2'd2;
    else begin
      lc_in  = 2'd0;
      hit_in = 1'b0;
    end
  end

  // Lowest task with all fingerprints ready, with the new ready bit included.
  logic [TASKS-1:0] rdy_new [3];
  logic             found;
  logic [TASK_BITS-1:0] found_t;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rdy_new[l] = rdy_r[l];
      if (lc_r == 2'(l)) rdy_new[l][req_r.task_number] = 1'b1;
    end
    found   = 1'b0;
    found_t = '0;
    for (int t = TASKS - 1; t >= 0; t--) begin
      if (rdy_new[0][t] && rdy_new[1][t] && (!triple_r[t] || rdy_new[2][t])) begin
        found   = 1'b1;
        found_t = TASK_BITS'(t);
      end
    end
  end

  logic accept_in, accept_out;
  assign in_stall   = (state_r != ST_IDLE) || (out_valid && out_stall);
  assign accept_in  = in_valid && !in_stall;
  assign accept_out = out_valid && !out_stall;

  logic [FP_ADDR_BITS-1:0] own_a;
  assign own_a = fp_addr(lc_r, req_r.task_number);

  // Read data with never-written entries shown as zero.
  logic [FP_ADDR_BITS-1:0] rd_a_r;
  logic [FP_WIDTH-1:0] rv;
  assign rv = written_r[rd_a_r] ? ram_rd : '0;

  // Stored value of the own entry merged with the high half.
  logic [FP_WIDTH-1:0] merged;
  assign merged = rv | {req_r.fingerprint_half, 16'd0};

  // RAM access: the own entry is read at accept and written back in EXEC, then the
  // compare reads the three entries of the selected task.
  always_comb begin
    ram_we = 1'b0;
    ram_wa = own_a;
    ram_wd = req_r.half_select ? merged : {16'd0, req_r.fingerprint_half};
    ram_ra = own_a;
    unique case (state_r)
      ST_IDLE: ram_ra = fp_addr(lc_in, in_data.task_number);
      ST_EXEC: begin
        ram_we = hit_r && req_r.kind == KIND_FP;
      end
      ST_RD0: ram_ra = fp_addr(2'd0, ct_r);
      ST_RD1: ram_ra = fp_addr(2'd1, ct_r);
      ST_RD2: ram_ra = fp_addr(2'd2, ct_r);
      default: ;
    endcase
  end

  logic [COUNT_BITS-1:0] tgt;
  assign tgt = tgt_r[req_r.task_number[3]][8*req_r.task_number[2:0] +: COUNT_BITS];

  // Check-in and completion decision of a state event.
  logic        ci_ok, all_in, complete;
  logic [31:0] succ_set;
  always_comb begin
    logic [TASK_BITS-1:0] t;
    t = req_r.task_number;
    ci_ok = hit_r && req_r.kind == KIND_STATE && !req_r.enter_flag && cout_r[lc_r][t];
    all_in = (cin_r[0][t] || lc_r == 2'd0) && (cin_r[1][t] || lc_r == 2'd1) &&
             (!triple_r[t] || cin_r[2][t] || lc_r == 2'd2);
    complete = ci_ok && all_in && (cnt_r[t] == tgt);
    succ_set = succ_r;
    if (!triple_r[t] || vote_r[t] == VOTE_ALL || vote_r[t] == VOTE_C1_OUT ||
        vote_r[t] == VOTE_C2_OUT) begin
      succ_set[2*t] = 1'b1;
    end else if (vote_r[t] == VOTE_C0_OUT) begin
      succ_set[2*t+1] = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept_in) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = (hit_r && req_r.kind == KIND_FP && req_r.half_select && found)
                           ? ST_RD0 : ST_IDLE;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_a_r <= ram_ra;
    if (accept_in) begin
      req_r <= in_data;
      lc_r  <= lc_in;
      hit_r <= hit_in && (in_data.kind == KIND_STATE || in_data.kind == KIND_FP);
    end
    if (state_r == ST_EXEC) ct_r <= found_t;
    // Stored values arrive in the cycle after each read.
    if (state_r == ST_RD1) fp_r[0] <= rv;
    if (state_r == ST_RD2) fp_r[1] <= rv;
  end

  logic [FP_WIDTH-1:0] f0, f1, f2;
  assign f0 = fp_r[0];
  assign f1 = fp_r[1];
  assign f2 = rv;

  // Main state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      written_r <= '0;
      succ_r    <= '0;
      fail_r    <= '0;
      irq_r     <= 1'b0;
      for (int l = 0; l < 3; l++) begin
        rdy_r[l]  <= '0;
        cout_r[l] <= '0;
        cin_r[l]  <= '0;
      end
      for (int t = 0; t < TASKS; t++) begin
        cnt_r[t]  <= '0;
        vote_r[t] <= VOTE_NONE;
      end
    end else begin
      state_r <= state_nxt;
      if (accept_out) out_valid <= 1'b0;
      if (ram_we) written_r[ram_wa] <= 1'b1;
      if (state_r == ST_EXEC) begin
        res_r.compared      <= 1'b0;
        res_r.compared_task <= '0;
        res_r.vote_result   <= VOTE_NONE;
        if (req_r.kind == KIND_CLEAR) begin
          succ_r <= '0;
          fail_r <= '0;
          irq_r  <= 1'b0;
          res_r.success_bits <= '0;
          res_r.failure_bits <= '0;
          res_r.irq          <= 1'b0;
          out_valid <= 1'b1;
        end else begin
          res_r.success_bits <= complete ? succ_set : succ_r;
          res_r.failure_bits <= fail_r;
          res_r.irq          <= complete || irq_r;
          if (!(hit_r && req_r.kind == KIND_FP && req_r.half_select && found)) begin
            out_valid <= 1'b1;
          end
          if (hit_r && req_r.kind == KIND_STATE && req_r.enter_flag) begin
            cout_r[lc_r][req_r.task_number] <= 1'b1;
          end
          if (complete) begin
            for (int l = 0; l < 3; l++) begin
              cin_r[l][req_r.task_number]  <= 1'b0;
              cout_r[l][req_r.task_number] <= 1'b0;
            end
            succ_r <= succ_set;
            cnt_r[req_r.task_number] <= '0;
            irq_r <= 1'b1;
          end else if (ci_ok) begin
            cin_r[lc_r][req_r.task_number] <= 1'b1;
          end
          if (hit_r && req_r.kind == KIND_FP && req_r.half_select) begin
            for (int l = 0; l < 3; l++) rdy_r[l] <= rdy_new[l];
          end
        end
      end
      if (state_r == ST_CMP) begin
        logic [TASK_BITS-1:0] t;
        logic [COUNT_BITS-1:0] c;
        t = ct_r;
        c = (cnt_r[t] == {COUNT_BITS{1'b1}}) ? cnt_r[t] : cnt_r[t] + 1'b1;
        res_r.compared      <= 1'b1;
        res_r.compared_task <= t;
        out_valid <= 1'b1;
        if (triple_r[t]) begin
          logic [2:0] v;
          v = vote3(f0, f1, f2);
          for (int l = 0; l < 3; l++) rdy_r[l][t] <= 1'b0;
          vote_r[t] <= v;
          cnt_r[t]  <= c;
          res_r.vote_result <= v;
        end else begin
          rdy_r[0][t] <= 1'b0;
          rdy_r[1][t] <= 1'b0;
          res_r.vote_result <= VOTE_NONE;
          if (f0 == f1) begin
            cnt_r[t] <= c;
          end else begin
            fail_r[t] <= 1'b1;
            irq_r     <= 1'b1;
            cnt_r[t]  <= '0;
            for (int l = 0; l < 2; l++) begin
              cin_r[l][t]  <= 1'b0;
              cout_r[l][t] <= 1'b0;
            end
            res_r.failure_bits <= fail_r | (16'd1 << t);
            res_r.irq          <= 1'b1;
          end
        end
      end
    end
  end

  assign out_data = res_r;

  // A result is never pending while a request is in progress.
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid) else $error("result pending during work");
  // A comparison always follows its three reads.
  a_cmp_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> $past(state_r == ST_RD2)) else $error("compare out of order");
  // A compared result reports the selected task.
  a_cmp_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |=> (out_valid && out_data.compared && out_data.compared_task == $past(ct_r)))
    else $error("compare result lost");

endmodule
